@@ rtl/core/smx_pkg.sv @@
// package for the softmax slice block
// constants, exp table and shared types; no dependencies
package smx_pkg;
  localparam int MaxLen   = 64;
  localparam int IdxW     = $clog2(MaxLen);
  localparam int CntW     = IdxW + 1;
  localparam int SumW     = IdxW + 17;
  localparam int ExpW     = 17;
  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic signed [15:0] MinLogit = -16'sd32768;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  function automatic logic [16:0] pow2_frac(input logic [4:0] j);
    logic [16:0] v;
    unique case (j)
      5'd0: v = 17'd65536;  5'd1: v = 17'd62757;  5'd2: v = 17'd60097;
      5'd3: v = 17'd57549;  5'd4: v = 17'd55109;  5'd5: v = 17'd52773;
      5'd6: v = 17'd50535;  5'd7: v = 17'd48393;  5'd8: v = 17'd46341;
      5'd9: v = 17'd44376;  5'd10: v = 17'd42495; 5'd11: v = 17'd40693;
      5'd12: v = 17'd38968; 5'd13: v = 17'd37316; 5'd14: v = 17'd35734;
      5'd15: v = 17'd34219; default: v = 17'd32768;
    endcase
    return v;
  endfunction
endpackage

@@ rtl/core/smx_if.sv @@
// valid/ready channel interfaces for the softmax slice
// depends on nothing
interface smx_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] logit;
  logic              last_in;
  modport source (output valid, logit, last_in, input ready);
  modport sink   (input valid, logit, last_in, output ready);
endinterface

interface smx_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] prob;
  logic        last_out;
  modport source (output valid, prob, last_out, input ready);
  modport sink   (input valid, prob, last_out, output ready);
endinterface

@@ rtl/core/softmax_slice.sv @@
// softmax over one slice: store, exp-sum pass, divide pass
// depends on smx_pkg, smx_if, smx_exp, smx_div
//
//  channel   dir  beat payload        handshake
//  in_if     in   logit, last_in      valid/ready
//  out_if    out  prob, last_out      valid/ready
//
// load: one logit per cycle into the element ram, max tracked on the fly
// sum pass: one ram read per cycle, exp unit pipelined
// divide pass: per element a ram read and exp, then the divider, then the beat is
//   registered and held until taken; the next element starts after that handshake
// input is held off (ready low) from the slice's end until its last beat leaves
// output stall freezes the divide pass; reset clears control, not the ram
module softmax_slice (
  input logic   clk_i,
  input logic   rst_ni,
  smx_in_if.sink    in_if,
  smx_out_if.source out_if
);
  import smx_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001, S_SUM = 5'b00010, S_RD = 5'b00100,
    S_DIV  = 5'b01000, S_OUT = 5'b10000
  } state_e;

  state_e state_q;
  logic signed [15:0] mem [MaxLen];
  logic signed [15:0] rdata_q, max_q, max_d;
  cnt_t cnt_q, idx_q;
  logic [SumW-1:0] sum_q;
  logic [3:0] vld_q;          // sum pass pipeline: ram, sub, exp t, exp out
  logic [4:0] rdp_q;          // divide pass: addr, ram, sub, exp t, exp out
  logic [15:0] a;
  logic [16:0] e;
  logic rd_en, div_start, div_done, acc, endslice;
  logic [15:0] q;
  logic [15:0] a_q;

  assign acc = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_LOAD);
  assign max_d = (in_if.logit > max_q) ? in_if.logit : max_q;
  assign endslice = in_if.last_in || (cnt_q == cnt_t'(MaxLen - 1));

  always_ff @(posedge clk_i) begin
    if (acc) mem[cnt_q[IdxW-1:0]] <= in_if.logit;
    rdata_q <= mem[idx_q[IdxW-1:0]];
  end

  assign a = 16'(max_q - rdata_q);
  always_ff @(posedge clk_i) a_q <= a;

  smx_exp u_exp (.clk_i, .a_i(a_q), .e_o(e));

  // exp result is valid once the read pipeline reaches its last stage
  assign div_start = rdp_q[4];
  smx_div u_div (.clk_i, .rst_ni, .start_i(div_start), .e_i(e), .den_i(sum_q),
                 .done_o(div_done), .q_o(q));

  assign rd_en = (state_q == S_SUM) && (idx_q < cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      max_q   <= MinLogit;
      cnt_q   <= '0;
      idx_q   <= '0;
      sum_q   <= '0;
      vld_q   <= '0;
      rdp_q   <= '0;
      out_if.valid <= 1'b0;
    end else begin
      vld_q <= {vld_q[2:0], rd_en};
      rdp_q <= {rdp_q[3:0], 1'b0};
      unique case (state_q)
        S_LOAD: if (acc) begin
          cnt_q <= cnt_q + cnt_t'(1);
          max_q <= max_d;
          if (endslice) begin
            state_q <= S_SUM;
            idx_q   <= '0;
            sum_q   <= '0;
          end
        end
        S_SUM: begin
          if (rd_en) idx_q <= idx_q + cnt_t'(1);
          if (vld_q[3]) sum_q <= sum_q + SumW'(e);
          if (!rd_en && vld_q == 4'd0 && idx_q == cnt_q) begin
            state_q <= S_RD;
            idx_q   <= '0;
            rdp_q   <= 5'b00001;
          end
        end
        S_RD: if (rdp_q[4]) state_q <= S_DIV;
        S_DIV: if (div_done) begin
          out_if.valid    <= 1'b1;
          out_if.last_out <= (idx_q + cnt_t'(1) == cnt_q);
          out_if.prob     <= q;
          state_q <= S_OUT;
        end
        S_OUT: if (out_if.ready) begin
          out_if.valid <= 1'b0;
          if (idx_q + cnt_t'(1) == cnt_q) begin
            state_q <= S_LOAD;
            cnt_q   <= '0;
            max_q   <= MinLogit;
            sum_q   <= '0;
          end else begin
            idx_q   <= idx_q + cnt_t'(1);
            rdp_q   <= 5'b00001;
            state_q <= S_RD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end
endmodule

@@ rtl/core/smx_exp.sv @@
// two-stage fixed-point exp(-a/256), Q1.16 result
// depends on smx_pkg
module smx_exp (
  input  logic        clk_i,
  input  logic [15:0] a_i,
  output logic [16:0] e_o
);
  import smx_pkg::*;
  logic [32:0] t_q;
  logic [16:0] hi, lo, base;
  logic [33:0] prod;
  logic [8:0]  n;
  always_ff @(posedge clk_i) t_q <= {17'd0, a_i} * {16'd0, Log2eQ16};
  assign n    = t_q[32:24];
  assign hi   = pow2_frac({1'b0, t_q[23:20]});
  assign lo   = pow2_frac({1'b0, t_q[23:20]} + 5'd1);
  assign prod = (hi - lo) * {1'b0, t_q[19:4]};
  assign base = hi - prod[32:16];
  always_ff @(posedge clk_i) e_o <= (n >= 9'd17) ? 17'd0 : (base >> n[4:0]);
endmodule

@@ rtl/core/smx_div.sv @@
// restoring divider: floor((num + den/2) / den) saturated to 16 bits
// depends on smx_pkg
module smx_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] e_i,
  input  logic [smx_pkg::SumW-1:0] den_i,
  output logic        done_o,
  output logic [15:0] q_o
);
  import smx_pkg::*;
  localparam int NumW = 34;
  logic [NumW-1:0] rem_q, rem_d;
  logic [NumW-1:0] quo_q;
  logic [SumW-1:0] den_q;
  logic [5:0]      cnt_q;
  logic            busy_q;
  logic [NumW:0]   trial;
  logic [NumW-1:0] num_q;

  assign rem_d = {rem_q[NumW-2:0], num_q[NumW-1]};
  assign trial = {1'b0, rem_d} - {{(NumW+1-SumW){1'b0}}, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {1'b0, e_i, 16'd0} + {{(NumW-SumW+1){1'b0}}, den_i[SumW-1:1]};
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      if (!trial[NumW]) begin
        rem_q <= trial[NumW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_d;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign q_o = (|quo_q[NumW-1:16]) ? 16'hFFFF : quo_q[15:0];
endmodule

@@ verif/smx_if.sv @@
// testbench side of the softmax slice channel interfaces
// the interfaces are taken from rtl/core/smx_if.sv; nothing is declared here

@@ verif/softmax_slice_test.sv @@
// testbench for softmax_slice: directed cases and random slices with idling on both channels
// depends on smx_pkg, smx_if and the softmax_slice rtl
module softmax_slice_test;
  import smx_pkg::*;

  typedef struct packed {
    logic [15:0] prob;
    logic        last_out;
  } prob_beat_t;

  // probability predictor and queue of expected beats
  class prob_board;
    logic signed [15:0] slice_q[$];
    logic signed [15:0] peak;
    prob_beat_t pending_q[$];
    int errors;

    function new();
      peak = MinLogit;
      errors = 0;
    endfunction

    function logic [16:0] pow2_frac_tb(logic [4:0] j);
      logic [16:0] tab[17];
      tab = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
              44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
      return tab[j];
    endfunction

    // exp(-a/256) as unsigned q1.16
    function logic [16:0] exp_neg(logic [15:0] a);
      logic [40:0] t;
      logic [4:0] k;
      logic [16:0] hi, lo;
      logic [32:0] prod;
      logic [16:0] base;
      t = a * 41'd94548;
      if (t[40:24] >= 17) return 17'd0;
      k = {1'b0, t[23:20]};
      hi = pow2_frac_tb(k);
      lo = pow2_frac_tb(k + 5'd1);
      prod = (hi - lo) * t[19:4];
      base = hi - prod[32:16];
      return base >> t[28:24];
    endfunction

    function void note_logit(logic signed [15:0] x, logic last);
      logic [31:0] total;
      logic [47:0] p;
      logic [16:0] e;
      prob_beat_t b;
      slice_q.push_back(x);
      if (x > peak) peak = x;
      if (slice_q.size() >= MaxLen) last = 1'b1;
      if (!last) return;
      total = 0;
      foreach (slice_q[i]) total += exp_neg(16'(peak - slice_q[i]));
      foreach (slice_q[i]) begin
        e = exp_neg(16'(peak - slice_q[i]));
        p = ({31'd0, e} << 16) + (total >> 1);
        p = p / total;
        b.prob = (p > 65535) ? 16'hffff : p[15:0];
        b.last_out = (i == slice_q.size() - 1);
        pending_q.push_back(b);
      end
      slice_q.delete();
      peak = MinLogit;
    endfunction

    function void check_prob(prob_beat_t got);
      prob_beat_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat prob=%0d last=%0b", $time, got.prob, got.last_out);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.prob !== want.prob) begin
        $display("%0t: prob expected %0d actual %0d", $time, want.prob, got.prob);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $display("%0t: last_out expected %0b actual %0b", $time, want.last_out,
                 got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  smx_in_if  in_if ();
  smx_out_if out_if ();

  softmax_slice dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if));

  prob_board board = new();
  bit no_idle = 1'b0;   // long stretch with no idling on either side
  int quiet = 0;        // cycles without any accepted beat

  initial begin
    in_if.valid = 1'b0;
    in_if.logit = '0;
    in_if.last_in = 1'b0;
    out_if.ready = 1'b0;
  end

  // sink side: random stalls, checks each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        board.check_prob('{prob: out_if.prob, last_out: out_if.last_out});
      out_if.ready <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  // watchdog: fails the run once the quiet counter passes its limit
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // send one beat, holding valid until accepted
  task automatic send_logit(logic signed [15:0] x, logic last);
    while (!no_idle && $urandom_range(99) < 31) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.logit <= x;
    in_if.last_in <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.note_logit(x, last);
  endtask

  task automatic send_slice(int len, int spread);
    logic signed [15:0] x;
    for (int i = 0; i < len; i++) begin
      if (spread == 0) x = 16'($urandom);
      else x = 16'($signed($urandom_range(2 * spread)) - spread);
      send_logit(x, i == len - 1);
    end
  endtask

  initial begin
    int sent;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: single element, extremes, ties, wide gap
    send_logit(16'sh7fff, 1'b1);
    send_logit(-16'sd32768, 1'b1);
    send_logit(16'sh7fff, 1'b0);
    send_logit(-16'sd32768, 1'b1);
    send_logit(16'sd256, 1'b0);
    send_logit(16'sd256, 1'b0);
    send_logit(16'sd0, 1'b1);
    send_logit(-16'sd1, 1'b0);
    send_logit(16'sd0, 1'b0);
    send_logit(16'sh5555, 1'b0);
    send_logit(-16'sh5556, 1'b1);
    // store full: slice ends without last mark
    for (int i = 0; i < MaxLen; i++) send_logit(16'($urandom_range(1023)), 1'b0);
    sent = 75;
    while (sent < 420) begin
      int len;
      no_idle = (sent > 200 && sent < 260);
      len = ($urandom_range(9) == 0) ? $urandom_range(MaxLen, 40) : $urandom_range(8, 1);
      case ($urandom_range(2))
        0: send_slice(len, 0);
        1: send_slice(len, 2048);
        default: send_slice(len, 64);
      endcase
      sent += len;
    end
    in_if.valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
